FILE: rtl/cst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cst_pkg;

   // field and datapath widths
   localparam int COORD_W       = 16;
   localparam int DIFF_W        = 17;
   localparam int PROD_W        = 34;
   localparam int DET_W         = 35;
   localparam int DEN_W         = 36;
   localparam int DMAT_W        = 24;
   localparam int DB_W          = 42;
   localparam int ACC_W         = 62;
   localparam int MAG_W         = 61;
   localparam int QUO_W         = 49;
   localparam int STIFF_W       = 48;
   localparam int IDX_W         = 3;
   localparam int MAT_FRAC_BITS = 16;
   localparam int CSR_IDX_W     = 2;

   // queue depths
   localparam int FQ_DEPTH = 4;
   localparam int OQ_DEPTH = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MATERIAL_DIAG     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MATERIAL_COUPLING = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MATERIAL_SHEAR    = 2'd2;

   // register reset values
   localparam logic signed [DMAT_W-1:0] DIAG_RESET     = 24'sd65536;
   localparam logic signed [DMAT_W-1:0] COUPLING_RESET = 24'sd0;
   localparam logic signed [DMAT_W-1:0] SHEAR_RESET    = 24'sd32768;

   localparam logic [IDX_W-1:0] LAST_IDX = 3'd5;

   // quotient limits and saturation values
   localparam logic [QUO_W-1:0]   QUO_CAP     = 49'h1_0000_0000_0000;
   localparam logic [QUO_W-1:0]   QUO_NEG_MAG = 49'h0_8000_0000_0000;
   localparam logic [QUO_W-1:0]   QUO_POS_MAX = 49'h0_7FFF_FFFF_FFFF;
   localparam logic [STIFF_W-1:0] STIFF_MAX   = 48'h7FFF_FFFF_FFFF;
   localparam logic [STIFF_W-1:0] STIFF_MIN   = 48'h8000_0000_0000;

   typedef struct packed {
      logic signed [DIFF_W-1:0] x10;
      logic signed [DIFF_W-1:0] x20;
      logic signed [DIFF_W-1:0] x21;
      logic signed [DIFF_W-1:0] y10;
      logic signed [DIFF_W-1:0] y20;
      logic signed [DIFF_W-1:0] y21;
   } diff_type;

   typedef struct packed {
      diff_type         d;
      logic [DEN_W-1:0] den;
      logic             degen;
   } tri_type;

   typedef struct packed {
      logic [IDX_W-1:0]          row;
      logic [IDX_W-1:0]          col;
      logic signed [STIFF_W-1:0] stiff;
      logic                      degen;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] mag;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [QUO_W-1:0] quo;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_EMIT
   } back_state_type;

   typedef enum logic [2:0] {
      MS_DB0_A,
      MS_DB0_B,
      MS_DB1_A,
      MS_DB1_B,
      MS_DB2,
      MS_NUM_A,
      MS_NUM_B,
      MS_NUM_C
   } mul_step_type;

endpackage
`default_nettype wire

FILE: rtl/cst_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module cst_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           data_in,
   input  wire logic                       pop,
   output logic [WIDTH-1:0]                data_out,
   output logic                            empty,
   output logic                            full,
   output logic [$clog2(DEPTH+1)-1:0]      count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   // handshake qualification
   assign do_push = push && (cnt_ff != CNT_W'(DEPTH));
   assign do_pop  = pop && (cnt_ff != '0);

   // pointer and fill count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= data_in;
      end
   end

   assign data_out = mem_ff[rd_ff];
   assign empty    = (cnt_ff == '0);
   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign count    = cnt_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("queue fill count beyond depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !full && !(pop && !empty)) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count missed a push");

endmodule
`default_nettype wire

FILE: rtl/cst_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cst_front
   import cst_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic signed [COORD_W-1:0]   node0_x,
   input  wire logic signed [COORD_W-1:0]   node0_y,
   input  wire logic signed [COORD_W-1:0]   node1_x,
   input  wire logic signed [COORD_W-1:0]   node1_y,
   input  wire logic signed [COORD_W-1:0]   node2_x,
   input  wire logic signed [COORD_W-1:0]   node2_y,
   input  wire logic                        push,
   output logic                             full,
   input  wire logic [$clog2(FQ_DEPTH+1)-1:0] q_count,
   output logic                             q_push,
   output tri_type                          q_data
);

   localparam int CNT_W = $clog2(FQ_DEPTH+1);

   logic                     v1_ff, v2_ff, v3_ff;
   diff_type                 d1_ff, d2_ff, d1_in;
   logic signed [PROD_W-1:0] pa_ff, pb_ff;
   tri_type                  t3_ff, t3_in;
   logic signed [DET_W-1:0]  det;
   logic [DET_W-1:0]         det_mag;
   logic [CNT_W:0]           credit;
   logic                     accept;

   // room is reserved for every transaction still in the pipeline
   assign credit = (CNT_W+1)'(q_count) + (CNT_W+1)'(v1_ff) + (CNT_W+1)'(v2_ff)
                 + (CNT_W+1)'(v3_ff);
   assign full   = (credit >= (CNT_W+1)'(FQ_DEPTH));
   assign accept = push && !full;

   // corner differences
   always_comb begin
      d1_in.x10 = DIFF_W'(node1_x) - DIFF_W'(node0_x);
      d1_in.x20 = DIFF_W'(node2_x) - DIFF_W'(node0_x);
      d1_in.x21 = DIFF_W'(node2_x) - DIFF_W'(node1_x);
      d1_in.y10 = DIFF_W'(node1_y) - DIFF_W'(node0_y);
      d1_in.y20 = DIFF_W'(node2_y) - DIFF_W'(node0_y);
      d1_in.y21 = DIFF_W'(node2_y) - DIFF_W'(node1_y);
   end

   // twice the signed area, its magnitude and the zero-area flag
   assign det     = DET_W'(pa_ff) - DET_W'(pb_ff);
   assign det_mag = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);

   always_comb begin
      t3_in.d     = d2_ff;
      t3_in.den   = {det_mag, 1'b0};
      t3_in.degen = (det == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      d1_ff <= d1_in;
      d2_ff <= d1_ff;
      pa_ff <= d1_ff.x10 * d1_ff.y20;
      pb_ff <= d1_ff.x20 * d1_ff.y10;
      t3_ff <= t3_in;
   end

   assign q_push = v3_ff;
   assign q_data = t3_ff;

endmodule
`default_nettype wire

FILE: rtl/cst_div.sv
`timescale 1ns / 1ps
`default_nettype none
module cst_div
   import cst_pkg::*;
#(
   parameter int RESULT_FRAC_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire div_req_type req,
   output div_rsp_type rsp
);

   localparam int NUM_W = MAG_W + RESULT_FRAC_BITS;
   localparam int DV_W  = DEN_W + MAT_FRAC_BITS;
   localparam int CNT_W = $clog2(QUO_W+1);

   logic [NUM_W-1:0] num;
   logic [DV_W-1:0]  dv, hi_ext;
   logic [DV_W-1:0]  rem_ff;
   logic [QUO_W-1:0] low_ff, quo_ff;
   logic             ovf_ff, busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DV_W:0]    trial, trial_diff;
   logic             ge, rnd, done;
   logic [QUO_W:0]   rounded;

   // scaled dividend and divisor
   assign num    = NUM_W'(req.mag) << RESULT_FRAC_BITS;
   assign dv     = {req.den, {MAT_FRAC_BITS{1'b0}}};
   assign hi_ext = DV_W'(num[NUM_W-1:QUO_W]);

   // one restoring step
   assign trial      = {rem_ff, low_ff[QUO_W-1]};
   assign trial_diff = trial - {1'b0, dv};
   assign ge         = (trial >= {1'b0, dv});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (req.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(QUO_W);
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= hi_ext;
         low_ff <= num[QUO_W-1:0];
         quo_ff <= '0;
         ovf_ff <= (hi_ext >= dv);
      end else if (busy_ff && (cnt_ff != '0)) begin
         rem_ff <= ge ? trial_diff[DV_W-1:0] : trial[DV_W-1:0];
         low_ff <= {low_ff[QUO_W-2:0], 1'b0};
         quo_ff <= {quo_ff[QUO_W-2:0], ge};
      end
   end

   // round half away from zero on the magnitude, cap at the limit
   assign rnd     = ({rem_ff, 1'b0} >= {1'b0, dv});
   assign rounded = {1'b0, quo_ff} + (QUO_W+1)'(rnd);
   assign done    = busy_ff && (cnt_ff == '0);

   always_comb begin
      rsp.busy = busy_ff;
      rsp.done = done;
      if (ovf_ff || (rounded > (QUO_W+1)'(QUO_CAP))) begin
         rsp.quo = QUO_CAP;
      end else begin
         rsp.quo = rounded[QUO_W-1:0];
      end
   end

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      req.start |=> busy_ff && (cnt_ff == CNT_W'(QUO_W)))
      else $error("divider did not start");

endmodule
`default_nettype wire

FILE: rtl/cst_back.sv
`timescale 1ns / 1ps
`default_nettype none
module cst_back
   import cst_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic signed [DMAT_W-1:0]  mat_diag,
   input  wire logic signed [DMAT_W-1:0]  mat_coupling,
   input  wire logic signed [DMAT_W-1:0]  mat_shear,
   input  wire logic                      item_valid,
   input  wire tri_type                   item,
   output logic                           item_pop,
   output div_req_type                    div_req,
   input  wire div_rsp_type               div_rsp,
   input  wire logic                      out_full,
   output logic                           out_push,
   output rsp_type                        out_data
);

   back_state_type            state_ff, state_in;
   mul_step_type              step_ff, step_in;
   tri_type                   item_ff;
   logic [IDX_W-1:0]          row_ff, col_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_sum, prod_t;
   logic signed [DB_W-1:0]    db0_ff, db1_ff, db2_ff;
   logic                      neg_ff;
   logic signed [STIFF_W-1:0] stiff_ff, sat;
   logic signed [DIFF_W-1:0]  bj0, bj1, bj2, bi0, bi1, bi2;
   logic signed [DB_W-1:0]    mul_a;
   logic signed [DMAT_W-1:0]  mul_b;
   logic signed [DB_W+DMAT_W-1:0] prod;
   logic                      load_item, mul_en, take_quo, advance, last_entry;
   logic [QUO_W-1:0]          neg_q;

   // one entry of the strain-displacement matrix
   function automatic logic signed [DIFF_W-1:0] b_elem(input diff_type d,
                                                      input logic [1:0] k,
                                                      input logic [IDX_W-1:0] c);
      logic signed [DIFF_W-1:0] v;
      v = '0;
      unique case (k)
         2'd0: begin
            unique case (c)
               3'd0:    v = -d.y21;
               3'd2:    v = d.y20;
               3'd4:    v = -d.y10;
               default: v = '0;
            endcase
         end
         2'd1: begin
            unique case (c)
               3'd1:    v = d.x21;
               3'd3:    v = -d.x20;
               3'd5:    v = d.x10;
               default: v = '0;
            endcase
         end
         2'd2: begin
            unique case (c)
               3'd0:    v = d.x21;
               3'd1:    v = -d.y21;
               3'd2:    v = -d.x20;
               3'd3:    v = d.y20;
               3'd4:    v = d.x10;
               3'd5:    v = -d.y10;
               default: v = '0;
            endcase
         end
         default: v = '0;
      endcase
      return v;
   endfunction

   assign bj0 = b_elem(item_ff.d, 2'd0, col_ff);
   assign bj1 = b_elem(item_ff.d, 2'd1, col_ff);
   assign bj2 = b_elem(item_ff.d, 2'd2, col_ff);
   assign bi0 = b_elem(item_ff.d, 2'd0, row_ff);
   assign bi1 = b_elem(item_ff.d, 2'd1, row_ff);
   assign bi2 = b_elem(item_ff.d, 2'd2, row_ff);

   // shared multiplier: D times B column, then B row times that
   always_comb begin
      unique case (step_ff)
         MS_DB0_A: begin mul_a = DB_W'(bj0); mul_b = mat_diag;     end
         MS_DB0_B: begin mul_a = DB_W'(bj1); mul_b = mat_coupling; end
         MS_DB1_A: begin mul_a = DB_W'(bj0); mul_b = mat_coupling; end
         MS_DB1_B: begin mul_a = DB_W'(bj1); mul_b = mat_diag;     end
         MS_DB2:   begin mul_a = DB_W'(bj2); mul_b = mat_shear;    end
         MS_NUM_A: begin mul_a = db0_ff;     mul_b = DMAT_W'(bi0); end
         MS_NUM_B: begin mul_a = db1_ff;     mul_b = DMAT_W'(bi1); end
         MS_NUM_C: begin mul_a = db2_ff;     mul_b = DMAT_W'(bi2); end
         default:  begin mul_a = '0;         mul_b = '0;           end
      endcase
   end

   assign prod    = mul_a * mul_b;
   assign prod_t  = prod[ACC_W-1:0];
   assign acc_sum = acc_ff + prod_t;

   assign last_entry = (row_ff == LAST_IDX) && (col_ff == LAST_IDX);

   // divider request
   always_comb begin
      div_req.start = (state_ff == ST_DIV_GO);
      div_req.mag   = acc_ff[ACC_W-1] ? MAG_W'(-acc_ff) : MAG_W'(acc_ff);
      div_req.den   = item_ff.den;
   end

   // sign and saturation of the quotient
   assign neg_q = QUO_W'(0) - div_rsp.quo;
   always_comb begin
      if (neg_ff) begin
         sat = (div_rsp.quo > QUO_NEG_MAG) ? STIFF_MIN : neg_q[STIFF_W-1:0];
      end else begin
         sat = (div_rsp.quo > QUO_POS_MAX) ? STIFF_MAX : div_rsp.quo[STIFF_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      load_item = 1'b0;
      mul_en    = 1'b0;
      take_quo  = 1'b0;
      advance   = 1'b0;
      item_pop  = 1'b0;
      out_push  = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            if (item_valid) begin
               load_item = 1'b1;
               item_pop  = 1'b1;
               step_in   = MS_DB0_A;
               state_in  = item.degen ? ST_EMIT : ST_MUL;
            end
         end
         ST_MUL: begin
            mul_en = 1'b1;
            unique case (step_ff)
               MS_DB0_A: step_in = MS_DB0_B;
               MS_DB0_B: step_in = MS_DB1_A;
               MS_DB1_A: step_in = MS_DB1_B;
               MS_DB1_B: step_in = MS_DB2;
               MS_DB2:   step_in = MS_NUM_A;
               MS_NUM_A: step_in = MS_NUM_B;
               MS_NUM_B: step_in = MS_NUM_C;
               MS_NUM_C: begin
                  step_in  = MS_DB0_A;
                  state_in = ST_DIV_GO;
               end
               default:  step_in = MS_DB0_A;
            endcase
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               take_quo = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!out_full) begin
               out_push = 1'b1;
               if (last_entry) begin
                  state_in = ST_LOAD;
               end else begin
                  advance  = 1'b1;
                  state_in = item_ff.degen ? ST_EMIT : ST_MUL;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         step_ff  <= MS_DB0_A;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (load_item) begin
         item_ff <= item;
         row_ff  <= '0;
         col_ff  <= '0;
      end else if (advance) begin
         if (col_ff == LAST_IDX) begin
            col_ff <= '0;
            row_ff <= row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
      if (mul_en) begin
         unique case (step_ff)
            MS_DB0_A: acc_ff <= prod_t;
            MS_DB0_B: db0_ff <= acc_sum[DB_W-1:0];
            MS_DB1_A: acc_ff <= prod_t;
            MS_DB1_B: db1_ff <= acc_sum[DB_W-1:0];
            MS_DB2:   db2_ff <= prod_t[DB_W-1:0];
            MS_NUM_A: acc_ff <= prod_t;
            MS_NUM_B: acc_ff <= acc_sum;
            MS_NUM_C: acc_ff <= acc_sum;
            default:  acc_ff <= acc_ff;
         endcase
      end
      if (div_req.start) begin
         neg_ff <= acc_ff[ACC_W-1];
      end
      if (take_quo) begin
         stiff_ff <= sat;
      end
   end

   // result transaction
   always_comb begin
      out_data.row   = row_ff;
      out_data.col   = col_ff;
      out_data.stiff = item_ff.degen ? '0 : stiff_ff;
      out_data.degen = item_ff.degen;
      out_data.last  = last_entry;
   end

   a_wait_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_WAIT) |-> div_rsp.busy)
      else $error("waiting on an idle divider");

   a_pop_on_load: assert property (@(posedge clock) disable iff (reset)
      item_pop |=> (row_ff == '0) && (col_ff == '0))
      else $error("new triangle did not restart at the first entry");

endmodule
`default_nettype wire

FILE: rtl/cst_triangle_stiffness_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel    direction  ports                                 transaction
// req        in         req_push / req_full, req_node*_x/y    one triangle
// rsp        out        rsp_pop / rsp_empty, rsp_*            one stiffness entry
// csr        in         csr_we, csr_index, csr_wdata          one register write
//
// each entry takes 8 passes through the shared multiplier, then
// the one-bit-per-cycle divider (49 quotient bits), then emit
// a triangle has 36 entries; a zero-area one skips the multiplier and divider
// the front accepts up to four triangles ahead of the back, so req_full rises only
// when that queue and the front pipeline are taken up; the result queue holds two entries
// synchronous active-high reset restores the material registers and empties both queues
module cst_triangle_stiffness_core
   import cst_pkg::*;
#(
   parameter int RESULT_FRAC_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic signed [COORD_W-1:0]   req_node0_x,
   input  wire logic signed [COORD_W-1:0]   req_node0_y,
   input  wire logic signed [COORD_W-1:0]   req_node1_x,
   input  wire logic signed [COORD_W-1:0]   req_node1_y,
   input  wire logic signed [COORD_W-1:0]   req_node2_x,
   input  wire logic signed [COORD_W-1:0]   req_node2_y,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic [IDX_W-1:0]                 rsp_row_index,
   output logic [IDX_W-1:0]                 rsp_col_index,
   output logic signed [STIFF_W-1:0]        rsp_stiffness,
   output logic                             rsp_degenerate,
   output logic                             rsp_last,
   input  wire logic                        csr_we,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [DMAT_W-1:0]           csr_wdata
);

   localparam int FQ_CNT_W = $clog2(FQ_DEPTH+1);
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH+1);

   logic signed [DMAT_W-1:0] diag_ff, coupling_ff, shear_ff;
   logic                     fq_push, fq_pop, fq_empty, fq_full;
   logic [FQ_CNT_W-1:0]      fq_count;
   tri_type                  fq_in, fq_out;
   logic                     oq_push, oq_full, oq_empty;
   logic [OQ_CNT_W-1:0]      oq_count;
   rsp_type                  oq_in, oq_out;
   div_req_type              div_req;
   div_rsp_type              div_rsp;

   // material registers
   always_ff @(posedge clock) begin
      if (reset) begin
         diag_ff     <= DIAG_RESET;
         coupling_ff <= COUPLING_RESET;
         shear_ff    <= SHEAR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MATERIAL_DIAG:     diag_ff     <= csr_wdata;
            CSR_MATERIAL_COUPLING: coupling_ff <= csr_wdata;
            CSR_MATERIAL_SHEAR:    shear_ff    <= csr_wdata;
            default:               diag_ff     <= diag_ff;
         endcase
      end
   end

   // front: differences and area
   cst_front u_front (
      .clock   (clock),
      .reset   (reset),
      .node0_x (req_node0_x),
      .node0_y (req_node0_y),
      .node1_x (req_node1_x),
      .node1_y (req_node1_y),
      .node2_x (req_node2_x),
      .node2_y (req_node2_y),
      .push    (req_push),
      .full    (req_full),
      .q_count (fq_count),
      .q_push  (fq_push),
      .q_data  (fq_in)
   );

   // triangle queue between front and back
   cst_queue #(
      .WIDTH ($bits(tri_type)),
      .DEPTH (FQ_DEPTH)
   ) u_tri_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fq_push),
      .data_in  (fq_in),
      .pop      (fq_pop),
      .data_out (fq_out),
      .empty    (fq_empty),
      .full     (fq_full),
      .count    (fq_count)
   );

   // back: per-entry products and quotient
   cst_back u_back (
      .clock        (clock),
      .reset        (reset),
      .mat_diag     (diag_ff),
      .mat_coupling (coupling_ff),
      .mat_shear    (shear_ff),
      .item_valid   (!fq_empty),
      .item         (fq_out),
      .item_pop     (fq_pop),
      .div_req      (div_req),
      .div_rsp      (div_rsp),
      .out_full     (oq_full),
      .out_push     (oq_push),
      .out_data     (oq_in)
   );

   cst_div #(
      .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // result queue
   cst_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OQ_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (oq_push),
      .data_in  (oq_in),
      .pop      (rsp_pop),
      .data_out (oq_out),
      .empty    (oq_empty),
      .full     (oq_full),
      .count    (oq_count)
   );

   assign rsp_empty      = oq_empty;
   assign rsp_row_index  = oq_out.row;
   assign rsp_col_index  = oq_out.col;
   assign rsp_stiffness  = oq_out.stiff;
   assign rsp_degenerate = oq_out.degen;
   assign rsp_last       = oq_out.last;

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_degenerate) |-> (rsp_stiffness == '0))
      else $error("zero-area entry carries a value");

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      fq_push |-> !fq_full)
      else $error("front pushed into a full triangle queue");

   a_oq_count: assert property (@(posedge clock) disable iff (reset)
      (oq_count == '0) == oq_empty)
      else $error("result queue count and empty disagree");

endmodule
`default_nettype wire
